// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL; clk and rst_n are taken from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/csc_pkg.sv =====
package csc_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pix_t;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] center_row;
        logic               found;
        logic               last_column;
    } res_t;

    // One column's state word in the column memory.
    typedef struct packed {
        logic [PIX_W-1:0]   above;
        logic [COORD_W-1:0] rise_row;
        logic [COORD_W-1:0] fall_row;
        logic               rise_seen;
        logic               fall_seen;
    } entry_t;

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic last_col;
    } flags_t;

endpackage

// ===== rtl/core/csc_stream_if.sv =====
interface csc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/csc_column_mem.sv =====
module csc_column_mem #(
    parameter int  DEPTH = csc_pkg::DEF_MAX_WIDTH,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output csc_pkg::entry_t rd_data,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  csc_pkg::entry_t wr_data
);
    import csc_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data while no new read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/csc_counter.sv =====
module csc_counter #(
    parameter int  MAX_WIDTH  = csc_pkg::DEF_MAX_WIDTH,
    parameter int  MAX_HEIGHT = csc_pkg::DEF_MAX_HEIGHT,
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int WDW = (CW + 1 > csc_pkg::CFG_W) ? CW + 1 : csc_pkg::CFG_W,
    localparam int HDW = (RW + 1 > csc_pkg::CFG_W) ? RW + 1 : csc_pkg::CFG_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [csc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          advance,
    input  logic                          frame_start,
    output logic [CW-1:0]                 col,
    output logic [RW-1:0]                 row,
    output csc_pkg::flags_t               flags
);
    import csc_pkg::*;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [WDW-1:0]   width_eff;
    logic [HDW-1:0]   height_eff;

    // Zero acts as one, anything past the maximum saturates.
    always_comb
    begin
        if (frame_width_reg == '0)
            width_eff = WDW'(1);
        else if (WDW'(frame_width_reg) > WDW'(MAX_WIDTH))
            width_eff = WDW'(MAX_WIDTH);
        else
            width_eff = WDW'(frame_width_reg);

        if (frame_height_reg == '0)
            height_eff = HDW'(1);
        else if (HDW'(frame_height_reg) > HDW'(MAX_HEIGHT))
            height_eff = HDW'(MAX_HEIGHT);
        else
            height_eff = HDW'(frame_height_reg);
    end

    always_comb
    begin
        col = frame_start ? '0 : col_reg;
        row = frame_start ? '0 : row_reg;

        flags.first_row = (row == '0);
        flags.last_col  = (WDW'(col) + WDW'(1)) >= width_eff;
        flags.last_row  = (HDW'(row) + HDW'(1)) >= height_eff;

        if (flags.last_col)
        begin
            col_next = '0;
            row_next = flags.last_row ? '0 : row + RW'(1);
        end
        else
        begin
            col_next = col + CW'(1);
            row_next = row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_FRAME_WIDTH)
                frame_width_reg <= cfg_data;
            if (cfg_write && cfg_index == CFG_FRAME_HEIGHT)
                frame_height_reg <= cfg_data;
            if (advance)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

// ===== rtl/core/csc_update.sv =====
module csc_update #(
    parameter int  MAX_WIDTH  = csc_pkg::DEF_MAX_WIDTH,
    parameter int  MAX_HEIGHT = csc_pkg::DEF_MAX_HEIGHT,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    output logic                      load_ready,
    input  logic [csc_pkg::PIX_W-1:0] px,
    input  logic [CW-1:0]             col,
    input  logic [RW-1:0]             row,
    input  csc_pkg::flags_t           flags,
    input  csc_pkg::entry_t           rd_data,
    output logic                      wr_en,
    output logic [CW-1:0]             wr_addr,
    output csc_pkg::entry_t           wr_data,
    csc_stream_if.source              res
);
    import csc_pkg::*;

    logic               s1_valid_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [RW-1:0]      s1_row_reg;
    logic [PIX_W-1:0]   s1_px_reg;
    flags_t             s1_flags_reg;
    logic               fwd_reg;
    entry_t             fwd_data_reg;
    logic               out_valid_reg;
    res_t               out_reg;

    entry_t             entry;
    entry_t             entry_new;
    logic [COORD_W-1:0] row_above;
    logic [COORD_W:0]   edge_sum;
    logic               found;
    logic               s1_fire;

    // A back-to-back access to the column just written reads stale memory data.
    assign entry     = fwd_reg ? fwd_data_reg : rd_data;
    assign row_above = COORD_W'(s1_row_reg - RW'(1));

    always_comb
    begin
        entry_new       = entry;
        entry_new.above = s1_px_reg;
        if (s1_flags_reg.first_row)
        begin
            entry_new.rise_seen = 1'b0;
            entry_new.fall_seen = 1'b0;
        end
        else if (entry.above == PIX_BLACK && s1_px_reg == PIX_WHITE)
        begin
            entry_new.rise_row  = row_above;
            entry_new.rise_seen = 1'b1;
        end
        else if (entry.above == PIX_WHITE && s1_px_reg == PIX_BLACK)
        begin
            entry_new.fall_row  = row_above;
            entry_new.fall_seen = 1'b1;
        end
    end

    assign found    = entry_new.rise_seen && entry_new.fall_seen;
    assign edge_sum = {1'b0, entry_new.rise_row} + {1'b0, entry_new.fall_row};

    // Stall only a last-row item that finds the output register full.
    assign s1_fire    = s1_valid_reg && (!s1_flags_reg.last_row || !out_valid_reg || res.ready);
    assign load_ready = !s1_valid_reg || s1_fire;

    assign wr_en   = s1_fire;
    assign wr_addr = s1_col_reg;
    assign wr_data = entry_new;

    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_fire && (s1_col_reg == col);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire && s1_flags_reg.last_row)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_col_reg   <= col;
            s1_row_reg   <= row;
            s1_px_reg    <= px;
            s1_flags_reg <= flags;
            fwd_data_reg <= entry_new;
        end
        if (s1_fire && s1_flags_reg.last_row)
        begin
            out_reg.column      <= COORD_W'(s1_col_reg);
            out_reg.center_row  <= found ? edge_sum[COORD_W:1] : '0;
            out_reg.found       <= found;
            out_reg.last_column <= s1_flags_reg.last_col;
        end
    end

endmodule

// ===== rtl/core/column_stripe_center_finder.sv =====
// Results: the last-row pixel of a column is held in stage 1, then its result is registered.
// Throughput: one pixel per cycle; the column memory does one read and one write per
// cycle, and a repeat access to the same column is served by forwarding. The input
// stalls only while a last-row pixel waits on a full result register.
// Reset: row and column counters clear, frame_width 640, frame_height 480; the column
// memory is not cleared, each entry is set up by the row-0 pixel of its column.
module column_stripe_center_finder #(
    parameter int MAX_WIDTH  = csc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = csc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [csc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csc_pkg::CFG_W-1:0]     cfg_data,
    csc_stream_if.sink                    pix,
    csc_stream_if.source                  res
);
    import csc_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic          in_fire;
    logic          in_ready;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    flags_t        flags;
    entry_t        rd_data;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    entry_t        wr_data;

    assign pix.ready = in_ready;
    assign in_fire   = pix.valid && in_ready;

    csc_counter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .advance     (in_fire),
        .frame_start (pix.payload.frame_start),
        .col         (col),
        .row         (row),
        .flags       (flags)
    );

    csc_column_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    csc_update #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire),
        .load_ready (in_ready),
        .px         (pix.payload.pixel),
        .col        (col),
        .row        (row),
        .flags      (flags),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .res        (res)
    );

`include "assert_macros.svh"

    `CSC_ASSERT_NEXT(a_last_row_gives_result, in_fire && flags.last_row, ##1 res.valid, "last-row pixel produced no result")
    `CSC_ASSERT_SAME(a_stall_only_on_full_out, !in_ready, res.valid && !res.ready, "input stalled without a blocked result")
    `CSC_ASSERT_SAME(a_write_follows_transfer, wr_en, $past(in_fire) || !in_ready || $past(!in_ready), "column write without a pending pixel")

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import csc_pkg::*;

    localparam int LAST_COL_LIMIT = DEF_MAX_WIDTH;
    localparam int LAST_ROW_LIMIT = DEF_MAX_HEIGHT;
    localparam int RANDOM_PIXELS  = 1100;
    localparam int SETTLE_CYCLES  = 4;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    csc_stream_if #(.payload_t(pix_t)) pix_if ();
    csc_stream_if #(.payload_t(res_t)) res_if ();

    column_stripe_center_finder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_if),
        .res       (res_if)
    );

    always #5 clk = ~clk;

    // Scan state mirrored on the testbench side
    logic [CFG_W-1:0] width_reg = RESET_FRAME_WIDTH;
    logic [CFG_W-1:0] height_reg = RESET_FRAME_HEIGHT;
    logic [PIX_W-1:0] above_px [LAST_COL_LIMIT];
    logic [COORD_W-1:0] rise_at [LAST_COL_LIMIT];
    logic [COORD_W-1:0] fall_at [LAST_COL_LIMIT];
    bit rise_seen [LAST_COL_LIMIT];
    bit fall_seen [LAST_COL_LIMIT];
    int unsigned scan_row = 0;
    int unsigned scan_col = 0;

    res_t pending_columns [$];
    int fail_count = 0;
    int pixels_sent = 0;
    int hold_cycles = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return 32'(v);
    endfunction

    function automatic void update_column_edges(pix_t item);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int unsigned mid;
        res_t r;
        w = clamp_dim(width_reg, LAST_COL_LIMIT);
        h = clamp_dim(height_reg, LAST_ROW_LIMIT);
        if (item.frame_start)
        begin
            scan_row = 0;
            scan_col = 0;
        end
        col = scan_col % LAST_COL_LIMIT;
        row = scan_row;
        if (row == 0)
        begin
            rise_seen[col] = 1'b0;
            fall_seen[col] = 1'b0;
        end
        else if (above_px[col] == PIX_BLACK && item.pixel == PIX_WHITE)
        begin
            rise_at[col] = COORD_W'(row - 1);
            rise_seen[col] = 1'b1;
        end
        else if (above_px[col] == PIX_WHITE && item.pixel == PIX_BLACK)
        begin
            fall_at[col] = COORD_W'(row - 1);
            fall_seen[col] = 1'b1;
        end
        above_px[col] = item.pixel;

        if (row + 1 >= h)
        begin
            r.column = COORD_W'(scan_col);
            r.found = rise_seen[col] && fall_seen[col];
            mid = r.found ? (int'(rise_at[col]) + int'(fall_at[col])) / 2 : 0;
            r.center_row = COORD_W'(mid);
            r.last_column = (scan_col + 1 >= w);
            pending_columns.push_back(r);
        end

        if (scan_col + 1 >= w)
        begin
            scan_col = 0;
            scan_row = (row + 1 >= h) ? 0 : row + 1;
        end
        else
            scan_col = scan_col + 1;
    endfunction

    function automatic void check_column_result(res_t got);
        res_t want;
        if (pending_columns.size() == 0)
        begin
            $error("unexpected result for column %0d", got.column);
            fail_count++;
            return;
        end
        want = pending_columns.pop_front();
        if (got.column !== want.column)
        begin
            $error("column: expected %0d, got %0d", want.column, got.column);
            fail_count++;
        end
        if (got.center_row !== want.center_row)
        begin
            $error("center_row: expected %0d, got %0d", want.center_row, got.center_row);
            fail_count++;
        end
        if (got.found !== want.found)
        begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_count++;
        end
        if (got.last_column !== want.last_column)
        begin
            $error("last_column: expected %0d, got %0d", want.last_column, got.last_column);
            fail_count++;
        end
    endfunction

    // Offer one pixel; returns at the edge where it transferred, valid still high
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
        int gap;
        pix_t item;
        item.pixel = px;
        item.frame_start = fs;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.payload <= item;
        do @(negedge clk); while (!pix_if.ready);
        @(posedge clk);
        update_column_edges(item);
        pixels_sent++;
    endtask

    // Drop valid and wait until every pending column has come out
    task automatic quiesce();
        pix_if.valid <= 1'b0;
        while (pending_columns.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        quiesce();
        cfg_write <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        width_reg = w;
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        height_reg = h;
        cfg_write <= 1'b0;
    endtask

    // Stripe per column on a black or white background, with grey noise
    task automatic run_frame(input int w, input int h, input int count,
                             input bit with_start, input bit noisy);
        int stripe_top [];
        int stripe_bot [];
        bit stripe_dark [];
        int r;
        int c;
        logic [PIX_W-1:0] px;
        logic fs;
        stripe_top = new[w];
        stripe_bot = new[w];
        stripe_dark = new[w];
        for (int i = 0; i < w; i++)
        begin
            stripe_top[i] = $urandom_range(0, h - 1);
            stripe_bot[i] = $urandom_range(stripe_top[i], h - 1);
            stripe_dark[i] = $urandom_range(0, 1);
        end
        for (int k = 0; k < count; k++)
        begin
            c = k % w;
            r = (k / w) % h;
            if (r >= stripe_top[c] && r <= stripe_bot[c])
                px = stripe_dark[c] ? PIX_WHITE : PIX_BLACK;
            else
                px = stripe_dark[c] ? PIX_BLACK : PIX_WHITE;
            if ($urandom_range(0, noisy ? 2 : 15) == 0)
                px = PIX_W'($urandom_range(0, 255));
            fs = (with_start && k == 0) || (noisy && $urandom_range(0, 29) == 0);
            send_pixel(px, fs);
        end
    endtask

    task automatic test_directed_edges();
        logic [PIX_W-1:0] grid [16] = '{
            8'd0,   8'd255, 8'd0,   8'd128,
            8'd255, 8'd0,   8'd255, 8'd128,
            8'd255, 8'd0,   8'd1,   8'd0,
            8'd0,   8'd255, 8'd254, 8'd255
        };
        // 4x4 frame: rise and fall in both orders, lone rise, grey levels
        set_frame(12'd4, 12'd4);
        for (int i = 0; i < 16; i++)
            send_pixel(grid[i], i == 0);
        // single-row frame: every pixel closes its column
        set_frame(12'd3, 12'd1);
        send_pixel(PIX_WHITE, 1'b1);
        send_pixel(PIX_BLACK, 1'b0);
        send_pixel(8'd7, 1'b0);
        // zero dimensions act as one
        set_frame(12'd0, 12'd0);
        send_pixel(PIX_BLACK, 1'b1);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(8'd85, 1'b1);
    endtask

    task automatic test_extreme_dimensions();
        // oversized width saturates; no early column closes the row
        set_frame(12'hFFF, 12'd1);
        run_frame(LAST_COL_LIMIT, 1, 64, 1'b1, 1'b0);
        // oversized height saturates on a one-column frame; no row closes early
        set_frame(12'd0, 12'hFFF);
        run_frame(1, LAST_ROW_LIMIT, 32, 1'b1, 1'b0);
        // largest legal size: only the start of a frame
        set_frame(12'd2048, 12'd2048);
        run_frame(LAST_COL_LIMIT, LAST_ROW_LIMIT, 32, 1'b1, 1'b0);
    endtask

    // Every column entry in use has been written by now, so resizing mid-frame is safe
    task automatic test_midframe_resize();
        int w;
        int h;
        for (int round = 0; round < 8; round++)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_frame(CFG_W'(w), CFG_W'(h));
            run_frame(w, h, $urandom_range(1, 2 * w * h),
                      round == 0 || $urandom_range(0, 1) == 0, 1'b0);
        end
    endtask

    task automatic test_backpressure();
        set_frame(12'd64, 12'd1);
        hold_cycles = 100;
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        run_frame(64, 1, 200, 1'b1, 1'b0);
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    task automatic test_random_frames();
        int start_count;
        int w;
        int h;
        int kind;
        start_count = pixels_sent;
        w = 8;
        h = 8;
        while (pixels_sent - start_count < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                w = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 20);
                h = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 12);
                set_frame(CFG_W'(w), CFG_W'(h));
            end
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind == 0)
                run_frame(w, h, $urandom_range(1, 60), $urandom_range(0, 1), 1'b1);
            else if (kind == 1 && w * h > 1)
                run_frame(w, h, $urandom_range(1, w * h - 1), 1'b1, 1'b0);
            else
                run_frame(w, h, w * h * $urandom_range(1, 2), 1'b1, 1'b0);
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // Result side: random stalls, one long hold when requested
    initial
    begin
        res_t got;
        int stall;
        res_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_cycles != 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
                stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(negedge clk); while (!res_if.valid);
            got = res_if.payload;
            @(posedge clk);
            check_column_result(got);
        end
    end

    initial
    begin
        #10_000_000;
        $display("** column_stripe_center_finder: FAILED **");
        $finish;
    end

    initial
    begin
        pix_t idle_item;
        idle_item.pixel = PIX_BLACK;
        idle_item.frame_start = 1'b0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= '0;
        pix_if.valid <= 1'b0;
        pix_if.payload <= idle_item;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_extreme_dimensions();
        test_midframe_resize();
        test_backpressure();
        test_random_frames();

        quiesce();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("** column_stripe_center_finder: PASSED **");
        else
            $display("** column_stripe_center_finder: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/csc_pkg.sv
rtl/core/csc_stream_if.sv
rtl/core/csc_column_mem.sv
rtl/core/csc_counter.sv
rtl/core/csc_update.sv
rtl/core/column_stripe_center_finder.sv
test/tb_top.sv
